FILE: sv/unicode_simple_case_fold_macros.svh
// Assertion helpers for the case-fold block.
`ifndef UNICODE_SIMPLE_CASE_FOLD_MACROS_SVH
`define UNICODE_SIMPLE_CASE_FOLD_MACROS_SVH

// Same-cycle implication.
`define UCF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ucf assertion failed");

// Next-cycle implication.
`define UCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ucf assertion failed");

`endif

FILE: sv/ucf_pkg.sv
`default_nettype none
package ucf_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned DeltaW = 17;
  localparam int unsigned IdxW   = 8;
  localparam logic [CpW-1:0] LastHi = 21'h01E921;

  typedef enum logic {
    KIND_ADD,
    KIND_ALT
  } kind_e;

  typedef struct packed {
    logic [CpW-1:0]           lo;
    logic [CpW-1:0]           hi;
    logic signed [DeltaW-1:0] delta;
    kind_e                    kind;
  } range_t;

  // Sorted range table; entries past the last range never match below max.
  function automatic range_t fold_entry(input logic [IdxW-1:0] idx);
    range_t e;
    case (idx)
      8'd0:   e = '{21'h0041, 21'h005A, 17'sd32, KIND_ADD};
      8'd1:   e = '{21'h00B5, 21'h00B5, 17'sd775, KIND_ADD};
      8'd2:   e = '{21'h00C0, 21'h00D6, 17'sd32, KIND_ADD};
      8'd3:   e = '{21'h00D8, 21'h00DE, 17'sd32, KIND_ADD};
      8'd4:   e = '{21'h0100, 21'h012E, 17'sd1, KIND_ALT};
      8'd5:   e = '{21'h0132, 21'h0136, 17'sd1, KIND_ALT};
      8'd6:   e = '{21'h0139, 21'h0147, 17'sd1, KIND_ALT};
      8'd7:   e = '{21'h014A, 21'h0176, 17'sd1, KIND_ALT};
      8'd8:   e = '{21'h0178, 21'h0178, -17'sd121, KIND_ADD};
      8'd9:   e = '{21'h0179, 21'h017D, 17'sd1, KIND_ALT};
      8'd10:  e = '{21'h017F, 21'h017F, -17'sd268, KIND_ADD};
      8'd11:  e = '{21'h0181, 21'h0181, 17'sd210, KIND_ADD};
      8'd12:  e = '{21'h0182, 21'h0184, 17'sd1, KIND_ALT};
      8'd13:  e = '{21'h0186, 21'h0186, 17'sd206, KIND_ADD};
      8'd14:  e = '{21'h0187, 21'h0187, 17'sd1, KIND_ADD};
      8'd15:  e = '{21'h0189, 21'h018A, 17'sd205, KIND_ADD};
      8'd16:  e = '{21'h018B, 21'h018B, 17'sd1, KIND_ADD};
      8'd17:  e = '{21'h018E, 21'h018E, 17'sd79, KIND_ADD};
      8'd18:  e = '{21'h018F, 21'h018F, 17'sd202, KIND_ADD};
      8'd19:  e = '{21'h0190, 21'h0190, 17'sd203, KIND_ADD};
      8'd20:  e = '{21'h0191, 21'h0191, 17'sd1, KIND_ADD};
      8'd21:  e = '{21'h0193, 21'h0193, 17'sd205, KIND_ADD};
      8'd22:  e = '{21'h0194, 21'h0194, 17'sd207, KIND_ADD};
      8'd23:  e = '{21'h0196, 21'h0196, 17'sd211, KIND_ADD};
      8'd24:  e = '{21'h0197, 21'h0197, 17'sd209, KIND_ADD};
      8'd25:  e = '{21'h0198, 21'h0198, 17'sd1, KIND_ADD};
      8'd26:  e = '{21'h019C, 21'h019C, 17'sd211, KIND_ADD};
      8'd27:  e = '{21'h019D, 21'h019D, 17'sd213, KIND_ADD};
      8'd28:  e = '{21'h019F, 21'h019F, 17'sd214, KIND_ADD};
      8'd29:  e = '{21'h01A0, 21'h01A4, 17'sd1, KIND_ALT};
      8'd30:  e = '{21'h01A6, 21'h01A6, 17'sd218, KIND_ADD};
      8'd31:  e = '{21'h01A7, 21'h01A7, 17'sd1, KIND_ADD};
      8'd32:  e = '{21'h01A9, 21'h01A9, 17'sd218, KIND_ADD};
      8'd33:  e = '{21'h01AC, 21'h01AC, 17'sd1, KIND_ADD};
      8'd34:  e = '{21'h01AE, 21'h01AE, 17'sd218, KIND_ADD};
      8'd35:  e = '{21'h01AF, 21'h01AF, 17'sd1, KIND_ADD};
      8'd36:  e = '{21'h01B1, 21'h01B2, 17'sd217, KIND_ADD};
      8'd37:  e = '{21'h01B3, 21'h01B5, 17'sd1, KIND_ALT};
      8'd38:  e = '{21'h01B7, 21'h01B7, 17'sd219, KIND_ADD};
      8'd39:  e = '{21'h01B8, 21'h01B8, 17'sd1, KIND_ADD};
      8'd40:  e = '{21'h01BC, 21'h01BC, 17'sd1, KIND_ADD};
      8'd41:  e = '{21'h01C4, 21'h01C4, 17'sd2, KIND_ADD};
      8'd42:  e = '{21'h01C5, 21'h01C5, 17'sd1, KIND_ADD};
      8'd43:  e = '{21'h01C7, 21'h01C7, 17'sd2, KIND_ADD};
      8'd44:  e = '{21'h01C8, 21'h01C8, 17'sd1, KIND_ADD};
      8'd45:  e = '{21'h01CA, 21'h01CA, 17'sd2, KIND_ADD};
      8'd46:  e = '{21'h01CB, 21'h01DB, 17'sd1, KIND_ALT};
      8'd47:  e = '{21'h01DE, 21'h01EE, 17'sd1, KIND_ALT};
      8'd48:  e = '{21'h01F1, 21'h01F1, 17'sd2, KIND_ADD};
      8'd49:  e = '{21'h01F2, 21'h01F4, 17'sd1, KIND_ALT};
      8'd50:  e = '{21'h01F6, 21'h01F6, -17'sd97, KIND_ADD};
      8'd51:  e = '{21'h01F7, 21'h01F7, -17'sd56, KIND_ADD};
      8'd52:  e = '{21'h01F8, 21'h021E, 17'sd1, KIND_ALT};
      8'd53:  e = '{21'h0220, 21'h0220, -17'sd130, KIND_ADD};
      8'd54:  e = '{21'h0222, 21'h0232, 17'sd1, KIND_ALT};
      8'd55:  e = '{21'h023A, 21'h023A, 17'sd10795, KIND_ADD};
      8'd56:  e = '{21'h023B, 21'h023B, 17'sd1, KIND_ADD};
      8'd57:  e = '{21'h023D, 21'h023D, -17'sd163, KIND_ADD};
      8'd58:  e = '{21'h023E, 21'h023E, 17'sd10792, KIND_ADD};
      8'd59:  e = '{21'h0241, 21'h0241, 17'sd1, KIND_ADD};
      8'd60:  e = '{21'h0243, 21'h0243, -17'sd195, KIND_ADD};
      8'd61:  e = '{21'h0244, 21'h0244, 17'sd69, KIND_ADD};
      8'd62:  e = '{21'h0245, 21'h0245, 17'sd71, KIND_ADD};
      8'd63:  e = '{21'h0246, 21'h024E, 17'sd1, KIND_ALT};
      8'd64:  e = '{21'h0345, 21'h0345, 17'sd116, KIND_ADD};
      8'd65:  e = '{21'h0370, 21'h0372, 17'sd1, KIND_ALT};
      8'd66:  e = '{21'h0376, 21'h0376, 17'sd1, KIND_ADD};
      8'd67:  e = '{21'h037F, 21'h037F, 17'sd116, KIND_ADD};
      8'd68:  e = '{21'h0386, 21'h0386, 17'sd38, KIND_ADD};
      8'd69:  e = '{21'h0388, 21'h038A, 17'sd37, KIND_ADD};
      8'd70:  e = '{21'h038C, 21'h038C, 17'sd64, KIND_ADD};
      8'd71:  e = '{21'h038E, 21'h038F, 17'sd63, KIND_ADD};
      8'd72:  e = '{21'h0391, 21'h03A1, 17'sd32, KIND_ADD};
      8'd73:  e = '{21'h03A3, 21'h03AB, 17'sd32, KIND_ADD};
      8'd74:  e = '{21'h03C2, 21'h03C2, 17'sd1, KIND_ADD};
      8'd75:  e = '{21'h03CF, 21'h03CF, 17'sd8, KIND_ADD};
      8'd76:  e = '{21'h03D0, 21'h03D0, -17'sd30, KIND_ADD};
      8'd77:  e = '{21'h03D1, 21'h03D1, -17'sd25, KIND_ADD};
      8'd78:  e = '{21'h03D5, 21'h03D5, -17'sd15, KIND_ADD};
      8'd79:  e = '{21'h03D6, 21'h03D6, -17'sd22, KIND_ADD};
      8'd80:  e = '{21'h03D8, 21'h03EE, 17'sd1, KIND_ALT};
      8'd81:  e = '{21'h03F0, 21'h03F0, -17'sd54, KIND_ADD};
      8'd82:  e = '{21'h03F1, 21'h03F1, -17'sd48, KIND_ADD};
      8'd83:  e = '{21'h03F4, 21'h03F4, -17'sd60, KIND_ADD};
      8'd84:  e = '{21'h03F5, 21'h03F5, -17'sd64, KIND_ADD};
      8'd85:  e = '{21'h03F7, 21'h03F7, 17'sd1, KIND_ADD};
      8'd86:  e = '{21'h03F9, 21'h03F9, -17'sd7, KIND_ADD};
      8'd87:  e = '{21'h03FA, 21'h03FA, 17'sd1, KIND_ADD};
      8'd88:  e = '{21'h03FD, 21'h03FF, -17'sd130, KIND_ADD};
      8'd89:  e = '{21'h0400, 21'h040F, 17'sd80, KIND_ADD};
      8'd90:  e = '{21'h0410, 21'h042F, 17'sd32, KIND_ADD};
      8'd91:  e = '{21'h0460, 21'h0480, 17'sd1, KIND_ALT};
      8'd92:  e = '{21'h048A, 21'h04BE, 17'sd1, KIND_ALT};
      8'd93:  e = '{21'h04C0, 21'h04C0, 17'sd15, KIND_ADD};
      8'd94:  e = '{21'h04C1, 21'h04CD, 17'sd1, KIND_ALT};
      8'd95:  e = '{21'h04D0, 21'h052E, 17'sd1, KIND_ALT};
      8'd96:  e = '{21'h0531, 21'h0556, 17'sd48, KIND_ADD};
      8'd97:  e = '{21'h10A0, 21'h10C5, 17'sd7264, KIND_ADD};
      8'd98:  e = '{21'h10C7, 21'h10C7, 17'sd7264, KIND_ADD};
      8'd99:  e = '{21'h10CD, 21'h10CD, 17'sd7264, KIND_ADD};
      8'd100: e = '{21'h13F8, 21'h13FD, -17'sd8, KIND_ADD};
      8'd101: e = '{21'h1C80, 21'h1C80, -17'sd6222, KIND_ADD};
      8'd102: e = '{21'h1C81, 21'h1C81, -17'sd6221, KIND_ADD};
      8'd103: e = '{21'h1C82, 21'h1C82, -17'sd6212, KIND_ADD};
      8'd104: e = '{21'h1C83, 21'h1C84, -17'sd6210, KIND_ADD};
      8'd105: e = '{21'h1C85, 21'h1C85, -17'sd6211, KIND_ADD};
      8'd106: e = '{21'h1C86, 21'h1C86, -17'sd6204, KIND_ADD};
      8'd107: e = '{21'h1C87, 21'h1C87, -17'sd6180, KIND_ADD};
      8'd108: e = '{21'h1C88, 21'h1C88, 17'sd35267, KIND_ADD};
      8'd109: e = '{21'h1C90, 21'h1CBA, -17'sd3008, KIND_ADD};
      8'd110: e = '{21'h1CBD, 21'h1CBF, -17'sd3008, KIND_ADD};
      8'd111: e = '{21'h1E00, 21'h1E94, 17'sd1, KIND_ALT};
      8'd112: e = '{21'h1E9B, 21'h1E9B, -17'sd58, KIND_ADD};
      8'd113: e = '{21'h1E9E, 21'h1E9E, -17'sd7615, KIND_ADD};
      8'd114: e = '{21'h1EA0, 21'h1EFE, 17'sd1, KIND_ALT};
      8'd115: e = '{21'h1F08, 21'h1F0F, -17'sd8, KIND_ADD};
      8'd116: e = '{21'h1F18, 21'h1F1D, -17'sd8, KIND_ADD};
      8'd117: e = '{21'h1F28, 21'h1F2F, -17'sd8, KIND_ADD};
      8'd118: e = '{21'h1F38, 21'h1F3F, -17'sd8, KIND_ADD};
      8'd119: e = '{21'h1F48, 21'h1F4D, -17'sd8, KIND_ADD};
      8'd120: e = '{21'h1F59, 21'h1F5F, -17'sd8, KIND_ALT};
      8'd121: e = '{21'h1F68, 21'h1F6F, -17'sd8, KIND_ADD};
      8'd122: e = '{21'h1F88, 21'h1F8F, -17'sd8, KIND_ADD};
      8'd123: e = '{21'h1F98, 21'h1F9F, -17'sd8, KIND_ADD};
      8'd124: e = '{21'h1FA8, 21'h1FAF, -17'sd8, KIND_ADD};
      8'd125: e = '{21'h1FB8, 21'h1FB9, -17'sd8, KIND_ADD};
      8'd126: e = '{21'h1FBA, 21'h1FBB, -17'sd74, KIND_ADD};
      8'd127: e = '{21'h1FBC, 21'h1FBC, -17'sd9, KIND_ADD};
      8'd128: e = '{21'h1FBE, 21'h1FBE, -17'sd7173, KIND_ADD};
      8'd129: e = '{21'h1FC8, 21'h1FCB, -17'sd86, KIND_ADD};
      8'd130: e = '{21'h1FCC, 21'h1FCC, -17'sd9, KIND_ADD};
      8'd131: e = '{21'h1FD8, 21'h1FD9, -17'sd8, KIND_ADD};
      8'd132: e = '{21'h1FDA, 21'h1FDB, -17'sd100, KIND_ADD};
      8'd133: e = '{21'h1FE8, 21'h1FE9, -17'sd8, KIND_ADD};
      8'd134: e = '{21'h1FEA, 21'h1FEB, -17'sd112, KIND_ADD};
      8'd135: e = '{21'h1FEC, 21'h1FEC, -17'sd7, KIND_ADD};
      8'd136: e = '{21'h1FF8, 21'h1FF9, -17'sd128, KIND_ADD};
      8'd137: e = '{21'h1FFA, 21'h1FFB, -17'sd126, KIND_ADD};
      8'd138: e = '{21'h1FFC, 21'h1FFC, -17'sd9, KIND_ADD};
      8'd139: e = '{21'h2126, 21'h2126, -17'sd7517, KIND_ADD};
      8'd140: e = '{21'h212A, 21'h212A, -17'sd8383, KIND_ADD};
      8'd141: e = '{21'h212B, 21'h212B, -17'sd8262, KIND_ADD};
      8'd142: e = '{21'h2132, 21'h2132, 17'sd28, KIND_ADD};
      8'd143: e = '{21'h2160, 21'h216F, 17'sd16, KIND_ADD};
      8'd144: e = '{21'h2183, 21'h2183, 17'sd1, KIND_ADD};
      8'd145: e = '{21'h24B6, 21'h24CF, 17'sd26, KIND_ADD};
      8'd146: e = '{21'h2C00, 21'h2C2F, 17'sd48, KIND_ADD};
      8'd147: e = '{21'h2C60, 21'h2C60, 17'sd1, KIND_ADD};
      8'd148: e = '{21'h2C62, 21'h2C62, -17'sd10743, KIND_ADD};
      8'd149: e = '{21'h2C63, 21'h2C63, -17'sd3814, KIND_ADD};
      8'd150: e = '{21'h2C64, 21'h2C64, -17'sd10727, KIND_ADD};
      8'd151: e = '{21'h2C67, 21'h2C6B, 17'sd1, KIND_ALT};
      8'd152: e = '{21'h2C6D, 21'h2C6D, -17'sd10780, KIND_ADD};
      8'd153: e = '{21'h2C6E, 21'h2C6E, -17'sd10749, KIND_ADD};
      8'd154: e = '{21'h2C6F, 21'h2C6F, -17'sd10783, KIND_ADD};
      8'd155: e = '{21'h2C70, 21'h2C70, -17'sd10782, KIND_ADD};
      8'd156: e = '{21'h2C72, 21'h2C72, 17'sd1, KIND_ADD};
      8'd157: e = '{21'h2C75, 21'h2C75, 17'sd1, KIND_ADD};
      8'd158: e = '{21'h2C7E, 21'h2C7F, -17'sd10815, KIND_ADD};
      8'd159: e = '{21'h2C80, 21'h2CE2, 17'sd1, KIND_ALT};
      8'd160: e = '{21'h2CEB, 21'h2CED, 17'sd1, KIND_ALT};
      8'd161: e = '{21'h2CF2, 21'h2CF2, 17'sd1, KIND_ADD};
      8'd162: e = '{21'hA640, 21'hA66C, 17'sd1, KIND_ALT};
      8'd163: e = '{21'hA680, 21'hA69A, 17'sd1, KIND_ALT};
      8'd164: e = '{21'hA722, 21'hA72E, 17'sd1, KIND_ALT};
      8'd165: e = '{21'hA732, 21'hA76E, 17'sd1, KIND_ALT};
      8'd166: e = '{21'hA779, 21'hA77B, 17'sd1, KIND_ALT};
      8'd167: e = '{21'hA77D, 21'hA77D, -17'sd35332, KIND_ADD};
      8'd168: e = '{21'hA77E, 21'hA786, 17'sd1, KIND_ALT};
      8'd169: e = '{21'hA78B, 21'hA78B, 17'sd1, KIND_ADD};
      8'd170: e = '{21'hA78D, 21'hA78D, -17'sd42280, KIND_ADD};
      8'd171: e = '{21'hA790, 21'hA792, 17'sd1, KIND_ALT};
      8'd172: e = '{21'hA796, 21'hA7A8, 17'sd1, KIND_ALT};
      8'd173: e = '{21'hA7AA, 21'hA7AA, -17'sd42308, KIND_ADD};
      8'd174: e = '{21'hA7AB, 21'hA7AB, -17'sd42319, KIND_ADD};
      8'd175: e = '{21'hA7AC, 21'hA7AC, -17'sd42315, KIND_ADD};
      8'd176: e = '{21'hA7AD, 21'hA7AD, -17'sd42305, KIND_ADD};
      8'd177: e = '{21'hA7AE, 21'hA7AE, -17'sd42308, KIND_ADD};
      8'd178: e = '{21'hA7B0, 21'hA7B0, -17'sd42258, KIND_ADD};
      8'd179: e = '{21'hA7B1, 21'hA7B1, -17'sd42282, KIND_ADD};
      8'd180: e = '{21'hA7B2, 21'hA7B2, -17'sd42261, KIND_ADD};
      8'd181: e = '{21'hA7B3, 21'hA7B3, 17'sd928, KIND_ADD};
      8'd182: e = '{21'hA7B4, 21'hA7C2, 17'sd1, KIND_ALT};
      8'd183: e = '{21'hA7C4, 21'hA7C4, -17'sd48, KIND_ADD};
      8'd184: e = '{21'hA7C5, 21'hA7C5, -17'sd42307, KIND_ADD};
      8'd185: e = '{21'hA7C6, 21'hA7C6, -17'sd35384, KIND_ADD};
      8'd186: e = '{21'hA7C7, 21'hA7C9, 17'sd1, KIND_ALT};
      8'd187: e = '{21'hA7D0, 21'hA7D0, 17'sd1, KIND_ADD};
      8'd188: e = '{21'hA7D6, 21'hA7D8, 17'sd1, KIND_ALT};
      8'd189: e = '{21'hA7F5, 21'hA7F5, 17'sd1, KIND_ADD};
      8'd190: e = '{21'hAB70, 21'hABBF, -17'sd38864, KIND_ADD};
      8'd191: e = '{21'hFF21, 21'hFF3A, 17'sd32, KIND_ADD};
      8'd192: e = '{21'h10400, 21'h10427, 17'sd40, KIND_ADD};
      8'd193: e = '{21'h104B0, 21'h104D3, 17'sd40, KIND_ADD};
      8'd194: e = '{21'h10570, 21'h1057A, 17'sd39, KIND_ADD};
      8'd195: e = '{21'h1057C, 21'h1058A, 17'sd39, KIND_ADD};
      8'd196: e = '{21'h1058C, 21'h10592, 17'sd39, KIND_ADD};
      8'd197: e = '{21'h10594, 21'h10595, 17'sd39, KIND_ADD};
      8'd198: e = '{21'h10C80, 21'h10CB2, 17'sd64, KIND_ADD};
      8'd199: e = '{21'h118A0, 21'h118BF, 17'sd32, KIND_ADD};
      8'd200: e = '{21'h16E40, 21'h16E5F, 17'sd32, KIND_ADD};
      8'd201: e = '{21'h1E900, 21'h1E921, 17'sd34, KIND_ADD};
      // padding: catches everything above the last range, adds nothing
      default: e = '{21'h1FFFFF, 21'h1FFFFF, 17'sd0, KIND_ADD};
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

FILE: sv/unicode_simple_case_fold.sv
// Pipeline: 8 search stages, then 1 apply stage, from input beat to output beat.
// Throughput: one code point per cycle while the output is not stalled; each stage does one probe of the range table.
// The whole pipeline holds in place while the output beat waits.
// Reset: asynchronous, active low; clears all stage valid bits, payload is not reset.
`default_nettype none
`include "unicode_simple_case_fold_macros.svh"
module unicode_simple_case_fold (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      code_point_valid_i,
  output logic                           code_point_ready_o,
  input  wire logic [ucf_pkg::CpW-1:0]   code_point_i,
  output logic                           folded_point_valid_o,
  input  wire logic                      folded_point_ready_i,
  output logic [ucf_pkg::CpW-1:0]        folded_point_o
);
  import ucf_pkg::*;

  localparam int unsigned NSt = IdxW;

  logic                 adv;
  logic [NSt-1:0]       vld_q, vld_d;
  logic [CpW-1:0]       cp_q  [NSt];
  logic [CpW-1:0]       cp_d  [NSt];
  logic [IdxW-1:0]      pos_q [NSt];
  logic [IdxW-1:0]      pos_d [NSt];
  logic                 out_vld_q;
  logic [CpW-1:0]       out_q, out_d, out_cp_q;
  range_t               hit;
  logic [CpW-1:0]       sum;

  assign adv = !out_vld_q || folded_point_ready_i;
  assign code_point_ready_o = adv;

  // lower-bound search: stage k settles index bit (NSt-1-k)
  always_comb begin
    logic [CpW-1:0]  pcp;
    logic [IdxW-1:0] ppos, probe, bitm;
    for (int k = 0; k < NSt; k++) begin
      pcp   = (k == 0) ? code_point_i : cp_q[(k == 0) ? 0 : k-1];
      ppos  = (k == 0) ? '0 : pos_q[(k == 0) ? 0 : k-1];
      bitm  = IdxW'(1) << (NSt-1-k);
      probe = ppos | (bitm - IdxW'(1));
      vld_d[k] = (k == 0) ? code_point_valid_i : vld_q[(k == 0) ? 0 : k-1];
      cp_d[k]  = pcp;
      pos_d[k] = (fold_entry(probe).hi < pcp) ? (ppos | bitm) : ppos;
    end
  end

  always_comb begin
    hit = fold_entry(pos_q[NSt-1]);
    sum = cp_q[NSt-1] + {{(CpW-DeltaW){hit.delta[DeltaW-1]}}, hit.delta};
    if (cp_q[NSt-1] < hit.lo) begin
      out_d = cp_q[NSt-1];
    end else if (hit.kind == KIND_ALT && (cp_q[NSt-1][0] ^ hit.lo[0])) begin
      out_d = cp_q[NSt-1];
    end else begin
      out_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= vld_d;
      out_vld_q <= vld_q[NSt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NSt; k++) begin
        cp_q[k]  <= cp_d[k];
        pos_q[k] <= pos_d[k];
      end
      out_q    <= out_d;
      out_cp_q <= cp_q[NSt-1];
    end
  end

  assign folded_point_valid_o = out_vld_q;
  assign folded_point_o       = out_q;

  `UCF_ASSERT_IMPL(a_above_pass, clk_i, rst_ni, out_vld_q && (out_cp_q > LastHi), out_q == out_cp_q)
  `UCF_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, vld_q[NSt-1] && !adv, vld_q[NSt-1])
  `UCF_ASSERT_NEXT(a_drain, clk_i, rst_ni, vld_q[NSt-1] && adv, out_vld_q)

endmodule
`default_nettype wire
